/* rtl/core/pgga_pkg.sv */
package pgga_pkg;

    localparam int GAIN_W  = 24;
    localparam int ERR_W   = 32;
    localparam int DUTY_W  = 17;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 48;
    localparam int DB_W    = 31;
    localparam int SMAG_W  = 22;
    localparam int SQ_W    = 63;
    localparam int LM_W    = 54;
    localparam int ACC_W   = 56;
    localparam int PROD_W  = 64;
    localparam int UC_AW   = 4;

    localparam logic [DUTY_W-1:0] DUTY_LO  = 17'd3277;
    localparam logic [DUTY_W-1:0] DUTY_HI  = 17'd62259;
    localparam logic [SMAG_W-1:0] ISUM_LIM = 22'd3276800;

    localparam logic [CFG_IW-1:0] CFG_RATE_P     = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_RATE_I     = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_STEP_LIMIT = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_DEAD_BAND  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_LEAK_RATE  = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_ANCHOR     = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_P_BOUNDS   = 3'd6;
    localparam logic [CFG_IW-1:0] CFG_I_BOUNDS   = 3'd7;

    localparam logic [23:0] RST_RATE_P     = 24'd83886;
    localparam logic [23:0] RST_RATE_I     = 24'd8389;
    localparam logic [23:0] RST_STEP_LIMIT = 24'd1678;
    localparam logic [30:0] RST_DEAD_BAND  = 31'd1311;
    localparam logic [23:0] RST_LEAK_RATE  = 24'd167772;
    localparam logic [47:0] RST_ANCHOR     = 48'd3659178690216;
    localparam logic [47:0] RST_P_BOUNDS   = 48'd22517994110321;
    localparam logic [47:0] RST_I_BOUNDS   = 48'd5629494333276;
    localparam logic [23:0] RST_KP         = 24'd771752;
    localparam logic [23:0] RST_KI         = 24'd218104;

    localparam logic [UC_AW-1:0] UC_EMIT = 4'd10;

    typedef struct packed {
        logic [GAIN_W-1:0] rate_p;
        logic [GAIN_W-1:0] rate_i;
        logic [GAIN_W-1:0] step_limit;
        logic [DB_W-1:0]   dead_band;
        logic [GAIN_W-1:0] leak_rate;
        logic [GAIN_W-1:0] anchor_p;
        logic [GAIN_W-1:0] anchor_i;
        logic [GAIN_W-1:0] p_lo;
        logic [GAIN_W-1:0] p_hi;
        logic [GAIN_W-1:0] i_lo;
        logic [GAIN_W-1:0] i_hi;
    } cfg_t;

    typedef enum logic [2:0] {
        MA_EMAG,
        MA_RATE_P,
        MA_RATE_I,
        MA_DMAG_P,
        MA_DMAG_I
    } ma_sel_t;

    typedef enum logic [2:0] {
        MB_EMAG,
        MB_SMAG,
        MB_X_LO,
        MB_X_HI,
        MB_Y_LO,
        MB_Y_HI,
        MB_LEAK
    } mb_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD_HI,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        ma_sel_t          ma;
        mb_sel_t          mb;
        acc_op_t          acc;
        logic             wr_d;
        logic             wr_x;
        logic             wr_y;
        logic             wr_sp;
        logic             wr_si;
        logic             wr_lp;
        logic             wr_li;
        logic             wr_kp;
        logic             wr_ki;
        logic             emit;
        logic             jmp_sat;
        logic [UC_AW-1:0] target;
    } ucode_t;

    // Each step issues one multiply and consumes the product issued one step earlier.
    function automatic ucode_t uc_rom(input logic [UC_AW-1:0] addr);
        ucode_t w;
        w = '0;
        case (addr)
            4'd0:
            begin
                w.ma = MA_EMAG;   w.mb = MB_EMAG;
                w.wr_d = 1'b1;    w.jmp_sat = 1'b1; w.target = UC_EMIT;
            end
            4'd1:
            begin
                w.ma = MA_EMAG;   w.mb = MB_SMAG;  w.wr_x = 1'b1;
            end
            4'd2:
            begin
                w.ma = MA_RATE_P; w.mb = MB_X_LO;  w.wr_y = 1'b1;
            end
            4'd3:
            begin
                w.ma = MA_RATE_P; w.mb = MB_X_HI;  w.acc = ACC_LOAD_HI;
            end
            4'd4:
            begin
                w.ma = MA_RATE_I; w.mb = MB_Y_LO;  w.acc = ACC_ADD;
            end
            4'd5:
            begin
                w.ma = MA_RATE_I; w.mb = MB_Y_HI;  w.acc = ACC_LOAD_HI; w.wr_sp = 1'b1;
            end
            4'd6:
            begin
                w.ma = MA_DMAG_P; w.mb = MB_LEAK;  w.acc = ACC_ADD;
            end
            4'd7:
            begin
                w.ma = MA_DMAG_I; w.mb = MB_LEAK;  w.wr_si = 1'b1; w.wr_lp = 1'b1;
            end
            4'd8:
            begin
                w.wr_li = 1'b1;   w.wr_kp = 1'b1;
            end
            4'd9:
            begin
                w.wr_ki = 1'b1;
            end
            UC_EMIT:
            begin
                w.emit = 1'b1;
            end
            default:
            begin
                w = '0;
            end
        endcase
        return w;
    endfunction

endpackage

/* rtl/core/pi_gain_gradient_adapter.sv */
// PI gain adapter: keeps Kp and Ki and adapts them once per control sample.
// Input channel in_valid/in_ready carries err_value, err_sum (Q16.16) and
// duty (Q1.16). Output channel out_valid/out_ready returns gain_p, gain_i
// (Q0.24) and adapted, one item per input item, in order.
// The configuration channel cfg_valid/cfg_ready writes register cfg_index
// with cfg_data; it is always ready and should only be used while idle.
// An item is worked by a short microprogram that shares one 32x32 multiplier
// and one gain update unit over eleven steps; the result is registered at the
// final step, and a new item is taken once the program has left that step.
// A saturated duty skips the rest of the program and returns the held gains.
// The output register lets the next item be accepted while a result waits.
// When the receiver stalls, the program waits at its final step until the
// output register is free; nothing is dropped.
// Reset loads the default register values and sets both gains to their
// anchors; no item is pending after reset.
module pi_gain_gradient_adapter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [pgga_pkg::ERR_W-1:0]  err_value,
    input  logic [pgga_pkg::ERR_W-1:0]  err_sum,
    input  logic [pgga_pkg::DUTY_W-1:0] duty,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [pgga_pkg::GAIN_W-1:0] gain_p,
    output logic [pgga_pkg::GAIN_W-1:0] gain_i,
    output logic                        adapted,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pgga_pkg::CFG_IW-1:0] cfg_index,
    input  logic [pgga_pkg::CFG_DW-1:0] cfg_data
);

    logic [23:0]             rate_p_reg;
    logic [23:0]             rate_i_reg;
    logic [23:0]             step_limit_reg;
    logic [30:0]             dead_band_reg;
    logic [23:0]             leak_rate_reg;
    logic [47:0]             anchor_reg;
    logic [47:0]             p_bounds_reg;
    logic [47:0]             i_bounds_reg;

    pgga_pkg::cfg_t          cfg;
    pgga_pkg::ucode_t        ctl;
    logic                    busy;
    logic                    start;
    logic                    out_free;
    logic                    sat;
    logic [pgga_pkg::GAIN_W-1:0] kp;
    logic [pgga_pkg::GAIN_W-1:0] ki;

    logic                    out_valid_reg;
    logic [pgga_pkg::GAIN_W-1:0] gain_p_reg;
    logic [pgga_pkg::GAIN_W-1:0] gain_i_reg;
    logic                    adapted_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = !busy;
    assign start     = in_valid && !busy;
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_p_reg     <= pgga_pkg::RST_RATE_P;
            rate_i_reg     <= pgga_pkg::RST_RATE_I;
            step_limit_reg <= pgga_pkg::RST_STEP_LIMIT;
            dead_band_reg  <= pgga_pkg::RST_DEAD_BAND;
            leak_rate_reg  <= pgga_pkg::RST_LEAK_RATE;
            anchor_reg     <= pgga_pkg::RST_ANCHOR;
            p_bounds_reg   <= pgga_pkg::RST_P_BOUNDS;
            i_bounds_reg   <= pgga_pkg::RST_I_BOUNDS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pgga_pkg::CFG_RATE_P:     rate_p_reg     <= cfg_data[23:0];
                pgga_pkg::CFG_RATE_I:     rate_i_reg     <= cfg_data[23:0];
                pgga_pkg::CFG_STEP_LIMIT: step_limit_reg <= cfg_data[23:0];
                pgga_pkg::CFG_DEAD_BAND:  dead_band_reg  <= cfg_data[30:0];
                pgga_pkg::CFG_LEAK_RATE:  leak_rate_reg  <= cfg_data[23:0];
                pgga_pkg::CFG_ANCHOR:     anchor_reg     <= cfg_data;
                pgga_pkg::CFG_P_BOUNDS:   p_bounds_reg   <= cfg_data;
                pgga_pkg::CFG_I_BOUNDS:   i_bounds_reg   <= cfg_data;
                default:                  rate_p_reg     <= rate_p_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg.rate_p     = rate_p_reg;
        cfg.rate_i     = rate_i_reg;
        cfg.step_limit = step_limit_reg;
        cfg.dead_band  = dead_band_reg;
        cfg.leak_rate  = leak_rate_reg;
        cfg.anchor_p   = anchor_reg[23:0];
        cfg.anchor_i   = anchor_reg[47:24];
        cfg.p_lo       = p_bounds_reg[23:0];
        cfg.p_hi       = p_bounds_reg[47:24];
        cfg.i_lo       = i_bounds_reg[23:0];
        cfg.i_hi       = i_bounds_reg[47:24];
    end

    pgga_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .sat      (sat),
        .out_free (out_free),
        .busy     (busy),
        .ctl      (ctl)
    );

    pgga_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .err_value (err_value),
        .err_sum   (err_sum),
        .duty      (duty),
        .cfg       (cfg),
        .ctl       (ctl),
        .sat       (sat),
        .kp        (kp),
        .ki        (ki)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            gain_p_reg  <= kp;
            gain_i_reg  <= ki;
            adapted_reg <= !sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign gain_p    = gain_p_reg;
    assign gain_i    = gain_i_reg;
    assign adapted   = adapted_reg;

`ifndef NO_ASSERTIONS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> out_free)
        else $error("Result emitted over an item still waiting at the output.");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy && !in_ready)
        else $error("Adapter did not go busy after accepting an item.");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |=> out_valid && !busy)
        else $error("Emitted result did not show at the output.");
`endif

endmodule

/* rtl/core/pgga_seq.sv */
module pgga_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            sat,
    input  logic            out_free,
    output logic            busy,
    output pgga_pkg::ucode_t ctl
);

    logic [pgga_pkg::UC_AW-1:0] step_reg;
    logic [pgga_pkg::UC_AW-1:0] step_next;
    logic                       busy_reg;
    logic                       busy_next;
    pgga_pkg::ucode_t           word;
    logic                       stall;

    always_comb
    begin
        word  = pgga_pkg::uc_rom(step_reg);
        stall = word.emit && !out_free;
        ctl   = (busy_reg && !stall) ? word : '0;
        step_next = step_reg;
        busy_next = busy_reg;
        priority if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg && !stall)
        begin
            priority if (word.emit)
                busy_next = 1'b0;
            else if (word.jmp_sat && sat)
                step_next = word.target;
            else
                step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    assign busy = busy_reg;

`ifndef NO_ASSERTIONS
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg <= pgga_pkg::UC_EMIT)
        else $error("Step counter ran past the end of the program.");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && stall |=> busy_reg && $stable(step_reg))
        else $error("Sequencer moved on while the result was blocked.");
`endif

endmodule

/* rtl/core/pgga_dp.sv */
module pgga_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pgga_pkg::ERR_W-1:0]  err_value,
    input  logic [pgga_pkg::ERR_W-1:0]  err_sum,
    input  logic [pgga_pkg::DUTY_W-1:0] duty,
    input  pgga_pkg::cfg_t              cfg,
    input  pgga_pkg::ucode_t            ctl,
    output logic                        sat,
    output logic [pgga_pkg::GAIN_W-1:0] kp,
    output logic [pgga_pkg::GAIN_W-1:0] ki
);

    localparam int GW = pgga_pkg::GAIN_W;
    localparam int NW = GW + 3;

    logic [pgga_pkg::ERR_W-1:0]  emag_reg;
    logic                        eneg_reg;
    logic [pgga_pkg::SMAG_W-1:0] smag_reg;
    logic                        ineg_reg;
    logic                        sat_reg;
    logic                        act_reg;

    logic [GW-1:0]               dpm_reg;
    logic                        dpn_reg;
    logic [GW-1:0]               dim_reg;
    logic                        din_reg;

    logic [pgga_pkg::SQ_W-1:0]   x_reg;
    logic [pgga_pkg::LM_W-1:0]   y_reg;
    logic [pgga_pkg::PROD_W-1:0] prod_reg;
    logic [pgga_pkg::ACC_W-1:0]  acc_reg;
    logic [GW-1:0]               sp_reg;
    logic [GW-1:0]               si_reg;
    logic [GW-1:0]               lp_reg;
    logic [GW-1:0]               li_reg;
    logic [GW-1:0]               kp_reg;
    logic [GW-1:0]               ki_reg;

    logic [pgga_pkg::ERR_W-1:0]  e_abs;
    logic [pgga_pkg::ERR_W-1:0]  s_abs;
    logic [pgga_pkg::SMAG_W-1:0] s_clip;
    logic [pgga_pkg::ERR_W-1:0]  op_a;
    logic [pgga_pkg::ERR_W-1:0]  op_b;
    logic [GW-1:0]               acc_clip;

    logic [GW-1:0]               u_g;
    logic [GW-1:0]               u_smag;
    logic                        u_sneg;
    logic [GW-1:0]               u_lmag;
    logic                        u_lneg;
    logic [GW-1:0]               u_lo;
    logic [GW-1:0]               u_hi;
    logic signed [NW-1:0]        u_step;
    logic signed [NW-1:0]        u_leak;
    logic signed [NW-1:0]        u_sum;
    logic [GW-1:0]               u_res;

    always_comb
    begin
        e_abs  = err_value[pgga_pkg::ERR_W-1] ? (~err_value + 1'b1) : err_value;
        s_abs  = err_sum[pgga_pkg::ERR_W-1] ? (~err_sum + 1'b1) : err_sum;
        s_clip = (s_abs > {10'd0, pgga_pkg::ISUM_LIM}) ? pgga_pkg::ISUM_LIM
                                                       : s_abs[pgga_pkg::SMAG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            emag_reg <= e_abs;
            eneg_reg <= err_value[pgga_pkg::ERR_W-1];
            smag_reg <= s_clip;
            ineg_reg <= err_value[pgga_pkg::ERR_W-1] ^ err_sum[pgga_pkg::ERR_W-1];
            sat_reg  <= (duty < pgga_pkg::DUTY_LO) || (duty > pgga_pkg::DUTY_HI);
            act_reg  <= e_abs >= {1'b0, cfg.dead_band};
        end
    end

    always_comb
    begin
        unique case (ctl.ma)
            pgga_pkg::MA_EMAG:   op_a = emag_reg;
            pgga_pkg::MA_RATE_P: op_a = {8'd0, cfg.rate_p};
            pgga_pkg::MA_RATE_I: op_a = {8'd0, cfg.rate_i};
            pgga_pkg::MA_DMAG_P: op_a = {8'd0, dpm_reg};
            pgga_pkg::MA_DMAG_I: op_a = {8'd0, dim_reg};
            default:             op_a = '0;
        endcase
        unique case (ctl.mb)
            pgga_pkg::MB_EMAG:   op_b = emag_reg;
            pgga_pkg::MB_SMAG:   op_b = {10'd0, smag_reg};
            pgga_pkg::MB_X_LO:   op_b = x_reg[31:0];
            pgga_pkg::MB_X_HI:   op_b = {1'b0, x_reg[62:32]};
            pgga_pkg::MB_Y_LO:   op_b = y_reg[31:0];
            pgga_pkg::MB_Y_HI:   op_b = {10'd0, y_reg[53:32]};
            pgga_pkg::MB_LEAK:   op_b = {8'd0, cfg.leak_rate};
            default:             op_b = '0;
        endcase
        acc_clip = (acc_reg > {32'd0, cfg.step_limit}) ? cfg.step_limit : acc_reg[GW-1:0];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        unique case (ctl.acc)
            pgga_pkg::ACC_LOAD_HI: acc_reg <= {24'd0, prod_reg[63:32]};
            pgga_pkg::ACC_ADD:     acc_reg <= acc_reg + prod_reg[pgga_pkg::ACC_W-1:0];
            default:               acc_reg <= acc_reg;
        endcase
        if (ctl.wr_x)
            x_reg <= prod_reg[pgga_pkg::SQ_W-1:0];
        if (ctl.wr_y)
            y_reg <= prod_reg[pgga_pkg::LM_W-1:0];
        if (ctl.wr_sp)
            sp_reg <= acc_clip;
        if (ctl.wr_si)
            si_reg <= acc_clip;
        if (ctl.wr_lp)
            lp_reg <= prod_reg[2*GW-1:GW];
        if (ctl.wr_li)
            li_reg <= prod_reg[2*GW-1:GW];
        if (ctl.wr_d)
        begin
            dpn_reg <= kp_reg < cfg.anchor_p;
            dpm_reg <= (kp_reg < cfg.anchor_p) ? (cfg.anchor_p - kp_reg)
                                               : (kp_reg - cfg.anchor_p);
            din_reg <= ki_reg < cfg.anchor_i;
            dim_reg <= (ki_reg < cfg.anchor_i) ? (cfg.anchor_i - ki_reg)
                                               : (ki_reg - cfg.anchor_i);
        end
    end

    // One gain update unit serves Kp and Ki in turn.
    always_comb
    begin
        u_g    = ctl.wr_ki ? ki_reg   : kp_reg;
        u_smag = ctl.wr_ki ? si_reg   : sp_reg;
        u_sneg = ctl.wr_ki ? ineg_reg : eneg_reg;
        u_lmag = ctl.wr_ki ? li_reg   : lp_reg;
        u_lneg = ctl.wr_ki ? din_reg  : dpn_reg;
        u_lo   = ctl.wr_ki ? cfg.i_lo : cfg.p_lo;
        u_hi   = ctl.wr_ki ? cfg.i_hi : cfg.p_hi;
        u_step = act_reg ? $signed({3'd0, u_smag}) : '0;
        if (u_sneg)
            u_step = -u_step;
        u_leak = $signed({3'd0, u_lmag});
        if (u_lneg)
            u_leak = -u_leak;
        u_sum = $signed({3'd0, u_g}) + u_step - u_leak;
        if (u_sum < $signed({3'd0, u_lo}))
            u_sum = $signed({3'd0, u_lo});
        if (u_sum > $signed({3'd0, u_hi}))
            u_sum = $signed({3'd0, u_hi});
        u_res = u_sum[GW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg <= pgga_pkg::RST_KP;
            ki_reg <= pgga_pkg::RST_KI;
        end
        else
        begin
            if (ctl.wr_kp)
                kp_reg <= u_res;
            if (ctl.wr_ki)
                ki_reg <= u_res;
        end
    end

    assign sat = sat_reg;
    assign kp  = kp_reg;
    assign ki  = ki_reg;

`ifndef NO_ASSERTIONS
    a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.wr_kp && ctl.wr_ki))
        else $error("Both gains were written through the shared update unit.");
`endif

endmodule
